@@ sv/jeo_pkg.sv @@
// ----------------------------------------------------------------------------
// jeo_pkg: shared definitions for the elimination-order block
// Field widths, default sizes and the reset value of the step register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jeo_pkg;

  // Fixed field widths
  localparam int unsigned ID_W   = 16;
  localparam int unsigned STEP_W = 10;

  // Default sizes
  localparam int unsigned MAX_MEMBERS_DEF = 64;
  localparam int unsigned ID_BITS_DEF     = 16;

  // Step register after reset
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);

endpackage : jeo_pkg

`default_nettype wire

@@ sv/jeo_mod.sv @@
// ----------------------------------------------------------------------------
// jeo_mod: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; gives dividend mod divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jeo_mod #(
  parameter int unsigned CNT_W = 7
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [jeo_pkg::STEP_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0]           divisor_i,
  output logic                            done_o,
  output logic [CNT_W-1:0]                rem_o
);
  import jeo_pkg::*;

  localparam int unsigned BitCntW = $clog2(STEP_W + 1);

  logic [STEP_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  logic               active_q, active_d;
  logic               done_q, done_d;
  logic [CNT_W:0]     shifted;
  logic [CNT_W:0]     diff;

  assign shifted = {rem_q, dvd_q[STEP_W-1]};
  assign diff    = shifted - {1'b0, divisor_i};

  always_comb begin
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    done_d   = 1'b0;
    if (start_i) begin
      dvd_d    = dividend_i;
      rem_d    = '0;
      cnt_d    = BitCntW'(STEP_W);
      active_d = 1'b1;
    end else if (active_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = (shifted >= {1'b0, divisor_i}) ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      dvd_d = {dvd_q[STEP_W-2:0], 1'b0};
      cnt_d = cnt_q - BitCntW'(1);
      if (cnt_q == BitCntW'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      active_q <= active_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule : jeo_mod

`default_nettype wire

@@ sv/jeo_mem.sv @@
// ----------------------------------------------------------------------------
// jeo_mem: member identifier store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jeo_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  import jeo_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule : jeo_mem

`default_nettype wire

@@ sv/josephus_elimination_order.sv @@
// ----------------------------------------------------------------------------
// josephus_elimination_order: counting-out order of a circle of members
// Loads identifiers into a circle and, on a run, emits them in elimination
// order for the programmed counting step.
// ----------------------------------------------------------------------------
// Usage: pulse start_i with cmd_i = 0 to add member_id_i to the circle; an add
// leaves busy_o low and no result follows. Adds beyond
// MAX_MEMBERS are dropped. Pulse start_i with cmd_i = 1 to run: busy_o rises
// and the block emits one transaction per member on eliminated_id_o, marked
// by valid_o for exactly one cycle, with last_out_o on the final one; then
// the circle is empty and busy_o falls. A run on an empty circle does nothing.
// The receiver cannot stall: sample every cycle in which valid_o is high.
// Steps per elimination: a launch state, the bit-serial remainder unit that
// folds (step - 1) modulo the survivors until its done strobe is seen, then
// the cursor walk slot by slot (at most MAX_MEMBERS - 1 slots, never a full
// lap) ending in a state that sees the count run out, then an emit state.
// Write cfg_we_i / cfg_wdata_i (the step) only while busy_o is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module josephus_elimination_order #(
  parameter int unsigned MAX_MEMBERS = jeo_pkg::MAX_MEMBERS_DEF,
  parameter int unsigned ID_BITS     = jeo_pkg::ID_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // command channel
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic                       cmd_i,
  input  wire logic [jeo_pkg::ID_W-1:0]   member_id_i,
  // step register
  input  wire logic                       cfg_we_i,
  input  wire logic [jeo_pkg::STEP_W-1:0] cfg_wdata_i,
  // results
  output logic                            valid_o,
  output logic [jeo_pkg::ID_W-1:0]        eliminated_id_o,
  output logic                            last_out_o
);
  import jeo_pkg::*;

  localparam int unsigned SlotW = $clog2(MAX_MEMBERS);
  localparam int unsigned CntW  = $clog2(MAX_MEMBERS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_DIV,
    S_WALK,
    S_EMIT
  } state_e;

  state_e                 state_q;
  logic [STEP_W-1:0]      step_q;
  logic [MAX_MEMBERS-1:0] alive_q;
  logic [CntW-1:0]        count_q;
  logic [CntW-1:0]        left_q;
  logic [CntW-1:0]        walk_q;
  logic [SlotW-1:0]       cursor_q;
  logic                   first_q;

  logic                   add_fire;
  logic                   run_fire;
  logic [SlotW-1:0]       cursor_nxt;
  logic [STEP_W-1:0]      dividend;
  logic                   div_done;
  logic [CntW-1:0]        div_rem;
  logic [ID_BITS-1:0]     rd_data;

  // A transaction is taken only in idle; adds past capacity fall away here.
  assign add_fire = start_i && !busy_o && !cmd_i && (count_q < CntW'(MAX_MEMBERS));
  assign run_fire = start_i && !busy_o && cmd_i && (count_q != '0);

  // Step one slot around the ring.
  assign cursor_nxt = (cursor_q == SlotW'(MAX_MEMBERS - 1)) ? '0 : cursor_q + SlotW'(1);

  // A step of one or less eliminates the current member: advance nothing.
  assign dividend = (step_q <= STEP_W'(1)) ? '0 : step_q - STEP_W'(1);

  jeo_mod #(
    .CNT_W (CntW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_LAUNCH),
    .dividend_i (dividend),
    .divisor_i  (left_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // The read address follows the cursor through the registered read port, so
  // the entry under the cursor is on rd_data in the emit state.
  jeo_mem #(
    .DEPTH (MAX_MEMBERS),
    .WIDTH (ID_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (add_fire),
    .waddr_i (count_q[SlotW-1:0]),
    .wdata_i (ID_BITS'(member_id_i)),
    .raddr_i (cursor_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      step_q   <= STEP_RESET;
      alive_q  <= '0;
      count_q  <= '0;
      left_q   <= '0;
      walk_q   <= '0;
      cursor_q <= '0;
      first_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (add_fire) begin
            alive_q[count_q[SlotW-1:0]] <= 1'b1;
            count_q                     <= count_q + CntW'(1);
          end
          if (run_fire) begin
            // Count from the first loaded member.
            left_q   <= count_q;
            cursor_q <= '0;
            first_q  <= 1'b1;
            state_q  <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            // After a removal, the move to the next survivor counts as one.
            walk_q  <= first_q ? div_rem : div_rem + CntW'(1);
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_q == '0) begin
            state_q <= S_EMIT;
          end else begin
            cursor_q <= cursor_nxt;
            if (alive_q[cursor_nxt]) begin
              walk_q <= walk_q - CntW'(1);
            end
          end
        end
        S_EMIT: begin
          first_q <= 1'b0;
          if (left_q == CntW'(1)) begin
            // Circle is empty: start over for the next load.
            alive_q  <= '0;
            count_q  <= '0;
            left_q   <= '0;
            cursor_q <= '0;
            state_q  <= S_IDLE;
          end else begin
            alive_q[cursor_q] <= 1'b0;
            left_q            <= left_q - CntW'(1);
            state_q           <= S_LAUNCH;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign valid_o         = (state_q == S_EMIT);
  assign eliminated_id_o = ID_W'(rd_data);
  assign last_out_o      = valid_o && (left_q == CntW'(1));

`ifndef SYNTHESIS
  // Results only come out of a run.
  a_valid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result strobe outside a run");

  // The last result ends the run.
  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_out_o) |=> !busy_o)
    else $error("block still busy after the last result");

  // A run starts only from a run command.
  a_run_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && cmd_i))
    else $error("run started without a run command");

  // Every emitted member is still alive in the circle.
  a_emit_alive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> alive_q[cursor_q])
    else $error("eliminated member was not alive");
`endif

endmodule : josephus_elimination_order

`default_nettype wire
